// File: hw/rtl/tvsg_pkg.sv
// ----------------------------------------------------------------------------
// tvsg_pkg
// shared types, codes and lookup functions of the three-voice sound generator
// ----------------------------------------------------------------------------
`default_nettype none

package tvsg_pkg;

  localparam int PRESCALE_LOG2_DEFAULT = 4;

  // sample queue geometry
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;
  localparam int OQ_CNT_W = 3;

  // input operation codes
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_FUNC = 2'd1,
    OP_DATA = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // bus function codes (value bits 7:6 of a function latch)
  typedef enum logic [1:0] {
    BUS_INACTIVE = 2'd0,
    BUS_READ     = 2'd1,
    BUS_WRITE    = 2'd2,
    BUS_ADDRESS  = 2'd3
  } bus_func_t;

  // register map
  localparam logic [3:0] REG_TONE_A_FINE   = 4'd0;
  localparam logic [3:0] REG_TONE_A_COARSE = 4'd1;
  localparam logic [3:0] REG_TONE_B_FINE   = 4'd2;
  localparam logic [3:0] REG_TONE_B_COARSE = 4'd3;
  localparam logic [3:0] REG_TONE_C_FINE   = 4'd4;
  localparam logic [3:0] REG_TONE_C_COARSE = 4'd5;
  localparam logic [3:0] REG_NOISE_PERIOD  = 4'd6;
  localparam logic [3:0] REG_MIXER         = 4'd7;
  localparam logic [3:0] REG_LEVEL_A       = 4'd8;
  localparam logic [3:0] REG_LEVEL_B       = 4'd9;
  localparam logic [3:0] REG_LEVEL_C       = 4'd10;
  localparam logic [3:0] REG_ENV_FINE      = 4'd11;
  localparam logic [3:0] REG_ENV_COARSE    = 4'd12;
  localparam logic [3:0] REG_ENV_SHAPE     = 4'd13;

  // channel codes on the output
  localparam logic CH_C = 1'b0;
  localparam logic CH_A = 1'b1;

  // programmed settings handed from the register file to the generators
  typedef struct packed {
    logic [2:0][11:0] tone_period;
    logic [7:0]       noise_period;
    logic [2:0]       tone_enable;
    logic [2:0]       noise_enable;
    logic [2:0][3:0]  amplitude;
    logic [2:0]       use_envelope;
    logic [15:0]      env_period;
    logic [3:0]       env_shape;
  } cfg_t;

  // one output sample
  typedef struct packed {
    logic              channel;
    logic signed [7:0] sample;
    logic              last;
  } sample_t;

  // fixed amplitude curve
  function automatic logic [7:0] amp_level(input logic [3:0] amp);
    logic [7:0] lvl;
    unique case (amp)
      4'd0:    lvl = 8'd1;
      4'd1:    lvl = 8'd1;
      4'd2:    lvl = 8'd2;
      4'd3:    lvl = 8'd3;
      4'd4:    lvl = 8'd5;
      4'd5:    lvl = 8'd7;
      4'd6:    lvl = 8'd11;
      4'd7:    lvl = 8'd15;
      4'd8:    lvl = 8'd22;
      4'd9:    lvl = 8'd31;
      4'd10:   lvl = 8'd45;
      4'd11:   lvl = 8'd63;
      4'd12:   lvl = 8'd90;
      4'd13:   lvl = 8'd127;
      4'd14:   lvl = 8'd180;
      default: lvl = 8'd255;
    endcase
    return lvl;
  endfunction

  // number of envelope steps before hold or repeat
  function automatic logic [5:0] shape_len(input logic [3:0] shape);
    logic [5:0] len;
    unique case (shape)
      4'd4, 4'd5, 4'd6, 4'd7, 4'd11, 4'd15: len = 6'd17;
      4'd10, 4'd14:                         len = 6'd32;
      default:                              len = 6'd16;
    endcase
    return len;
  endfunction

  // envelope volume at a position of a shape
  function automatic logic [3:0] shape_value(input logic [3:0] shape,
                                             input logic [4:0] pos);
    logic [3:0] p;
    logic       second;
    logic [3:0] v;
    p      = pos[3:0];
    second = pos[4];
    unique case (shape)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd8, 4'd9: v = ~p;
      4'd4, 4'd5, 4'd6, 4'd7, 4'd15:      v = second ? 4'd0 : p;
      4'd10:                              v = second ? p : ~p;
      4'd11:                              v = second ? 4'd15 : ~p;
      4'd12, 4'd13:                       v = p;
      default:                            v = second ? ~p : p;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tvsg_regs.sv
// ----------------------------------------------------------------------------
// tvsg_regs
// bus function latch, register select and programmable register file
// ----------------------------------------------------------------------------
`default_nettype none

module tvsg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          fire,
  input  wire tvsg_pkg::op_t op,
  input  wire logic [7:0]    value,
  output tvsg_pkg::cfg_t     cfg,
  output logic               shape_restart
);

  tvsg_pkg::bus_func_t function_latch;
  logic [3:0]          selected_register;
  logic                data_write;

  assign data_write    = fire && (op == tvsg_pkg::OP_DATA) &&
                         (function_latch == tvsg_pkg::BUS_WRITE);
  assign shape_restart = data_write && (selected_register == tvsg_pkg::REG_ENV_SHAPE);

  always_ff @(posedge clk) begin
    if (rst) begin
      function_latch    <= tvsg_pkg::BUS_INACTIVE;
      selected_register <= '0;
      cfg               <= '0;
    end else if (fire) begin
      if (op == tvsg_pkg::OP_FUNC) begin
        function_latch <= tvsg_pkg::bus_func_t'(value[7:6]);
      end else if (op == tvsg_pkg::OP_DATA &&
                   function_latch == tvsg_pkg::BUS_ADDRESS) begin
        selected_register <= value[3:0];
      end else if (data_write) begin
        unique case (selected_register)
          tvsg_pkg::REG_TONE_A_FINE:   cfg.tone_period[0][7:0]  <= value;
          tvsg_pkg::REG_TONE_A_COARSE: cfg.tone_period[0][11:8] <= value[3:0];
          tvsg_pkg::REG_TONE_B_FINE:   cfg.tone_period[1][7:0]  <= value;
          tvsg_pkg::REG_TONE_B_COARSE: cfg.tone_period[1][11:8] <= value[3:0];
          tvsg_pkg::REG_TONE_C_FINE:   cfg.tone_period[2][7:0]  <= value;
          tvsg_pkg::REG_TONE_C_COARSE: cfg.tone_period[2][11:8] <= value[3:0];
          tvsg_pkg::REG_NOISE_PERIOD:  cfg.noise_period         <= value;
          tvsg_pkg::REG_MIXER: begin
            // enables are active low on the bus
            cfg.tone_enable  <= ~value[2:0];
            cfg.noise_enable <= ~value[5:3];
          end
          tvsg_pkg::REG_LEVEL_A: begin
            cfg.amplitude[0]    <= value[3:0];
            cfg.use_envelope[0] <= value[4];
          end
          tvsg_pkg::REG_LEVEL_B: begin
            cfg.amplitude[1]    <= value[3:0];
            cfg.use_envelope[1] <= value[4];
          end
          tvsg_pkg::REG_LEVEL_C: begin
            cfg.amplitude[2]    <= value[3:0];
            cfg.use_envelope[2] <= value[4];
          end
          tvsg_pkg::REG_ENV_FINE:      cfg.env_period[7:0]  <= value;
          tvsg_pkg::REG_ENV_COARSE:    cfg.env_period[15:8] <= value;
          tvsg_pkg::REG_ENV_SHAPE:     cfg.env_shape        <= value[3:0];
          default: begin
            // unused registers ignore writes
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tvsg_gen.sv
// ----------------------------------------------------------------------------
// tvsg_gen
// envelope, noise and tone generators with the per-voice mixer
// ----------------------------------------------------------------------------
`default_nettype none

module tvsg_gen (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire logic           shape_restart,
  input  wire tvsg_pkg::cfg_t cfg,
  output logic [7:0]          level_a,
  output logic [7:0]          level_c
);

  // envelope state
  logic [15:0] env_counter;
  logic [4:0]  env_position;
  logic [3:0]  env_volume;
  // noise state
  logic [7:0]  noise_counter;
  logic [16:0] noise_lfsr;
  logic        noise_bit;
  // tone state
  logic [2:0][11:0] tone_counter;
  logic [2:0]       tone_bit;

  logic [15:0] env_inc;
  logic        env_fire;
  logic        env_hold;
  logic [5:0]  env_len;
  logic [5:0]  pos_inc;
  logic [5:0]  pos_next;
  logic [3:0]  env_volume_next;

  logic [7:0]  noise_inc;
  logic        noise_fire;
  logic [17:0] lfsr_fb;
  logic [16:0] noise_lfsr_next;
  logic        noise_bit_next;

  logic [2:0][11:0] tone_inc;
  logic [2:0]       tone_fire;
  logic [2:0][11:0] tone_counter_next;
  logic [2:0]       tone_bit_next;
  logic [2:0]       gate;

  // envelope: hold follows the shape code directly
  always_comb begin
    env_inc         = env_counter + 16'd1;
    env_fire        = (env_inc >= cfg.env_period);
    env_hold        = cfg.env_shape[0] | ~cfg.env_shape[3];
    env_len         = tvsg_pkg::shape_len(cfg.env_shape);
    pos_inc         = {1'b0, env_position} + 6'd1;
    if (pos_inc >= env_len) begin
      pos_next = env_hold ? (env_len - 6'd1) : 6'd0;
    end else begin
      pos_next = pos_inc;
    end
    env_volume_next = env_fire ? tvsg_pkg::shape_value(cfg.env_shape, env_position)
                               : env_volume;
  end

  // noise: 17-bit lfsr, level toggles when the two low bits differ
  always_comb begin
    noise_inc       = noise_counter + 8'd1;
    noise_fire      = (noise_inc >= cfg.noise_period);
    lfsr_fb         = {1'b0, noise_lfsr} ^ (noise_lfsr[0] ? 18'h24000 : 18'h00000);
    noise_lfsr_next = noise_fire ? lfsr_fb[17:1] : noise_lfsr;
    noise_bit_next  = noise_bit ^ (noise_fire & (noise_lfsr[0] ^ noise_lfsr[1]));
  end

  // tones and gates, one independent lane per voice
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tone_inc[i]          = tone_counter[i] + 12'd1;
      tone_fire[i]         = (tone_inc[i] >= cfg.tone_period[i]);
      tone_counter_next[i] = tone_fire[i] ? 12'd0 : tone_inc[i];
      tone_bit_next[i]     = tone_bit[i] ^ tone_fire[i];
      gate[i]              = (cfg.noise_enable[i] & noise_bit_next) |
                             (cfg.tone_enable[i] & tone_bit_next[i]);
    end
    level_a = !gate[0] ? 8'd0 :
              cfg.use_envelope[0] ? {4'd0, env_volume_next}
                                  : tvsg_pkg::amp_level(cfg.amplitude[0]);
    level_c = !gate[2] ? 8'd0 :
              cfg.use_envelope[2] ? {4'd0, env_volume_next}
                                  : tvsg_pkg::amp_level(cfg.amplitude[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      env_counter   <= '0;
      env_position  <= '0;
      env_volume    <= '0;
      noise_counter <= '0;
      noise_lfsr    <= 17'd1;
      noise_bit     <= 1'b1;
      tone_counter  <= '0;
      tone_bit      <= '0;
    end else if (step) begin
      if (env_fire) begin
        env_counter  <= '0;
        env_position <= pos_next[4:0];
      end else begin
        env_counter  <= env_inc;
      end
      env_volume    <= env_volume_next;
      noise_counter <= noise_fire ? 8'd0 : noise_inc;
      noise_lfsr    <= noise_lfsr_next;
      noise_bit     <= noise_bit_next;
      tone_counter  <= tone_counter_next;
      tone_bit      <= tone_bit_next;
    end else if (shape_restart) begin
      env_position <= '0;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tvsg_outq.sv
// ----------------------------------------------------------------------------
// tvsg_outq
// four-entry sample queue, filled a pair at a time, drained one per transaction
// ----------------------------------------------------------------------------
`default_nettype none

module tvsg_outq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire tvsg_pkg::sample_t first,
  input  wire tvsg_pkg::sample_t second,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tvsg_pkg::sample_t      head
);

  tvsg_pkg::sample_t entries [tvsg_pkg::OQ_DEPTH];

  logic [tvsg_pkg::OQ_PTR_W-1:0] wptr;
  logic [tvsg_pkg::OQ_PTR_W-1:0] rptr;
  logic [tvsg_pkg::OQ_CNT_W-1:0] count;
  logic                          pop;

  assign room      = (count <= tvsg_pkg::OQ_CNT_W'(tvsg_pkg::OQ_DEPTH - 2));
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign head      = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr]        <= first;
      entries[wptr + 2'd1] <= second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 2'd2;
      end
      if (pop) begin
        rptr <= rptr + 2'd1;
      end
      count <= count + (push ? 3'd2 : 3'd0) - (pop ? 3'd1 : 3'd0);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/three_voice_sound_generator_core.sv
// ----------------------------------------------------------------------------
// three_voice_sound_generator_core
// three-voice programmable sound generator with bus-style register access
// ----------------------------------------------------------------------------
//
//  port group | direction | handshake            | payload
//  -----------+-----------+----------------------+---------------------------
//  input      | in        | in_valid / in_ready  | op[1:0], value[7:0]
//  output     | out       | out_valid / out_ready| channel, sample[7:0], last
//
//  - one input transaction per clock while in_ready is high; an accepted item
//    sits in the item register, then updates all state in a single pass
//  - every 2**PRESCALE_LOG2 ticks a pair of samples (channel C, then A) is
//    written into a four-entry queue; the item stage stalls only when an
//    update tick finds fewer than two queue entries free, so sustained rate
//    is one item a cycle unless every tick is an update tick or out_ready
//    is held low (then the single output port sets the rate)
//  - rst is synchronous; all control state and the register file clear
//  - back-pressure on out_ready fills the queue, then holds the item register
//
`default_nettype none

module three_voice_sound_generator_core #(
  parameter int PRESCALE_LOG2 = tvsg_pkg::PRESCALE_LOG2_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        op,
  input  wire logic [7:0]        value,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   channel,
  output logic signed [7:0]      sample,
  output logic                   last
);

  // a zero prescale still needs one phase bit; it simply never leaves zero
  localparam int PHASE_W = (PRESCALE_LOG2 > 0) ? PRESCALE_LOG2 : 1;
  localparam logic [PHASE_W-1:0] PHASE_MAX = PHASE_W'((1 << PRESCALE_LOG2) - 1);

  // item register
  logic                item_valid;
  tvsg_pkg::op_t       item_op;
  logic [7:0]          item_value;

  // prescaler
  logic [PHASE_W-1:0]  tick_phase;
  logic                phase_wrap;

  logic                is_tick;
  logic                produces;
  logic                fire;
  logic                step;

  tvsg_pkg::cfg_t      cfg;
  logic                shape_restart;
  logic [7:0]          level_a;
  logic [7:0]          level_c;

  logic                room;
  tvsg_pkg::sample_t   pair_first;
  tvsg_pkg::sample_t   pair_second;
  tvsg_pkg::sample_t   head;

  // the tick that wraps the prescaler is the update tick
  assign is_tick    = (item_op == tvsg_pkg::OP_TICK);
  assign phase_wrap = (tick_phase == PHASE_MAX);
  assign produces   = is_tick && phase_wrap;

  // an item retires unless it needs two queue slots that are not free
  assign fire     = item_valid && (!produces || room);
  assign step     = fire && produces;
  assign in_ready = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // payload of the item register needs no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_op    <= tvsg_pkg::op_t'(op);
      item_value <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_phase <= '0;
    end else if (fire && is_tick) begin
      tick_phase <= phase_wrap ? '0 : tick_phase + 1'b1;
    end
  end

  tvsg_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .op            (item_op),
    .value         (item_value),
    .cfg           (cfg),
    .shape_restart (shape_restart)
  );

  tvsg_gen u_gen (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .shape_restart (shape_restart),
    .cfg           (cfg),
    .level_a       (level_a),
    .level_c       (level_c)
  );

  // level minus 128 is the level with its top bit flipped
  always_comb begin
    pair_first.channel  = tvsg_pkg::CH_C;
    pair_first.sample   = $signed(level_c ^ 8'h80);
    pair_first.last     = 1'b0;
    pair_second.channel = tvsg_pkg::CH_A;
    pair_second.sample  = $signed(level_a ^ 8'h80);
    pair_second.last    = 1'b1;
  end

  tvsg_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .first     (pair_first),
    .second    (pair_second),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign channel = head.channel;
  assign sample  = head.sample;
  assign last    = head.last;

  // a stalled item keeps its register contents
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !fire |=> item_valid && $stable(item_op) && $stable(item_value))
    else $error("item register changed while stalled");

  // an update tick always leaves a sample waiting
  assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("update tick produced no output");

  // channel A always closes the pair, channel C always opens it
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (channel == last))
    else $error("sample pair out of order");

endmodule

`default_nettype wire

// File: tb/three_voice_sound_generator_core_tb.sv
// ----------------------------------------------------------------------------
// three_voice_sound_generator_core_tb
// self-checking bench for the three-voice sound generator core
// ----------------------------------------------------------------------------
// drives ticks, bus function latches and data writes over the input channel.
// a scoreboard class keeps its own copy of the register file, tone, noise and
// envelope generators and predicts each channel c / channel a sample pair. the
// output channel is checked field by field. random idling on both sides, one
// long output hold-off and several full drains are mixed in.
// ----------------------------------------------------------------------------
`default_nettype none

module three_voice_sound_generator_core_tb;
  import tvsg_pkg::*;

  // registers 14 and 15 exist in the address space but hold nothing
  localparam logic [3:0] REG_SPARE_14 = 4'd14;
  localparam logic [3:0] REG_SPARE_15 = 4'd15;

  // mapping of the 4-bit fixed level to an output level
  localparam logic [7:0] LEVEL_CURVE [16] = '{
    8'd1, 8'd1, 8'd2, 8'd3, 8'd5, 8'd7, 8'd11, 8'd15,
    8'd22, 8'd31, 8'd45, 8'd63, 8'd90, 8'd127, 8'd180, 8'd255
  };

  localparam int RANDOM_ITEMS = 1100;
  localparam int HOLD_LEN     = 300;   // cycles of output back-pressure
  localparam int SETTLE       = 24;    // cycles after the last sample
  localparam int MAX_REPORTS  = 60;

  // --------------------------------------------------------------------------
  // sample predictor and scoreboard
  // --------------------------------------------------------------------------
  class sound_scoreboard;
    int unsigned phase;
    bus_func_t   bus_mode;
    logic [3:0]  reg_sel;
    logic [11:0] tone_per [3];
    logic [11:0] tone_cnt [3];
    logic        tone_bit [3];
    logic [3:0]  amp [3];
    logic        use_env [3];
    logic [2:0]  tone_en;
    logic [2:0]  noise_en;
    logic [7:0]  noise_per;
    logic [7:0]  noise_cnt;
    logic [16:0] lfsr;
    logic        noise_bit;
    logic [15:0] env_per;
    logic [15:0] env_cnt;
    logic [3:0]  env_shape;
    logic [4:0]  env_pos;
    logic        env_hold;
    logic [3:0]  env_vol;

    sample_t     expected_samples [$];
    int          failures;
    int          checked;

    function new();
      phase     = 0;
      bus_mode  = BUS_INACTIVE;
      reg_sel   = '0;
      for (int i = 0; i < 3; i++) begin
        tone_per[i] = '0;
        tone_cnt[i] = '0;
        tone_bit[i] = 1'b0;
        amp[i]      = '0;
        use_env[i]  = 1'b0;
      end
      tone_en   = '0;
      noise_en  = '0;
      noise_per = '0;
      noise_cnt = '0;
      lfsr      = 17'd1;
      noise_bit = 1'b1;
      env_per   = '0;
      env_cnt   = '0;
      env_shape = '0;
      env_pos   = '0;
      env_hold  = 1'b1;
      env_vol   = '0;
      failures  = 0;
      checked   = 0;
    endfunction

    function int unsigned steps_in_shape(logic [3:0] shp);
      case (shp)
        4'd4, 4'd5, 4'd6, 4'd7, 4'd11, 4'd15: return 17;
        4'd10, 4'd14:                         return 32;
        default:                              return 16;
      endcase
    endfunction

    // ramp value: pos[3:0] counts within a half, pos[4] marks the second half
    function logic [3:0] shape_level(logic [3:0] shp, logic [4:0] pos);
      logic [3:0] up;
      logic [3:0] down;
      up   = pos[3:0];
      down = 4'd15 - pos[3:0];
      case (shp)
        4'd4, 4'd5, 4'd6, 4'd7, 4'd15: return pos[4] ? 4'd0 : up;
        4'd10:                         return pos[4] ? up : down;
        4'd11:                         return pos[4] ? 4'd15 : down;
        4'd12, 4'd13:                  return up;
        4'd14:                         return pos[4] ? down : up;
        default:                       return down;
      endcase
    endfunction

    function void write_register(logic [7:0] data);
      int idx;
      idx = reg_sel[2:1];
      case (reg_sel)
        REG_TONE_A_FINE, REG_TONE_B_FINE, REG_TONE_C_FINE:
          tone_per[idx][7:0] = data;
        REG_TONE_A_COARSE, REG_TONE_B_COARSE, REG_TONE_C_COARSE:
          tone_per[idx][11:8] = data[3:0];
        REG_NOISE_PERIOD: noise_per = data;
        REG_MIXER: begin
          tone_en  = ~data[2:0];
          noise_en = ~data[5:3];
        end
        REG_LEVEL_A, REG_LEVEL_B, REG_LEVEL_C: begin
          idx          = reg_sel - REG_LEVEL_A;
          amp[idx]     = data[3:0];
          use_env[idx] = data[4];
        end
        REG_ENV_FINE:   env_per[7:0]  = data;
        REG_ENV_COARSE: env_per[15:8] = data;
        REG_ENV_SHAPE: begin
          env_shape = data[3:0];
          env_pos   = '0;
          env_hold  = data[0] | ~data[3];
        end
        default: ;
      endcase
    endfunction

    function void advance_envelope();
      int unsigned span;
      logic [5:0]  nxt;
      env_cnt = env_cnt + 16'd1;
      if (env_cnt >= env_per) begin
        span    = steps_in_shape(env_shape);
        env_cnt = '0;
        env_vol = shape_level(env_shape, env_pos);
        nxt     = {1'b0, env_pos} + 6'd1;
        if (nxt >= span) nxt = env_hold ? 6'(span - 1) : 6'd0;
        env_pos = nxt[4:0];
      end
    endfunction

    function void advance_noise();
      logic [17:0] wide;
      noise_cnt = noise_cnt + 8'd1;
      if (noise_cnt >= noise_per) begin
        if (lfsr[0] ^ lfsr[1]) noise_bit = ~noise_bit;
        wide = {1'b0, lfsr};
        if (wide[0]) wide = wide ^ 18'h24000;
        lfsr      = wide[17:1];
        noise_cnt = '0;
      end
    endfunction

    function logic [7:0] advance_voice(int ch);
      logic gate_open;
      tone_cnt[ch] = tone_cnt[ch] + 12'd1;
      if (tone_cnt[ch] >= tone_per[ch]) begin
        tone_bit[ch] = ~tone_bit[ch];
        tone_cnt[ch] = '0;
      end
      gate_open = (noise_en[ch] & noise_bit) | (tone_en[ch] & tone_bit[ch]);
      if (!gate_open) return 8'd0;
      return use_env[ch] ? {4'd0, env_vol} : LEVEL_CURVE[amp[ch]];
    endfunction

    function void take_item(op_t kind, logic [7:0] data);
      sample_t    s;
      logic [7:0] lvl_a;
      logic [7:0] lvl_c;
      case (kind)
        OP_FUNC: bus_mode = bus_func_t'(data[7:6]);
        OP_DATA: begin
          if (bus_mode == BUS_WRITE) write_register(data);
          else if (bus_mode == BUS_ADDRESS) reg_sel = data[3:0];
        end
        OP_TICK: begin
          phase = (phase + 1) & ((1 << PRESCALE_LOG2_DEFAULT) - 1);
          if (phase == 0) begin
            advance_envelope();
            advance_noise();
            lvl_a = advance_voice(0);
            void'(advance_voice(1));
            lvl_c = advance_voice(2);
            s.channel = CH_C;
            s.sample  = lvl_c ^ 8'h80;
            s.last    = 1'b0;
            expected_samples.push_back(s);
            s.channel = CH_A;
            s.sample  = lvl_a ^ 8'h80;
            s.last    = 1'b1;
            expected_samples.push_back(s);
          end
        end
        default: ;
      endcase
    endfunction

    function void flag(string what, int want, int got);
      failures++;
      if (failures <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void check_sample(logic ch, logic signed [7:0] smp, logic lst);
      sample_t want;
      if (expected_samples.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: sample with none expected, expected nothing, got ch %0d val %0d",
                   $time, ch, smp);
        return;
      end
      want = expected_samples.pop_front();
      checked++;
      if (ch !== want.channel) flag("channel", want.channel, ch);
      if (smp !== want.sample) flag("sample", $signed(want.sample), $signed(smp));
      if (lst !== want.last) flag("last", want.last, lst);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, dut and shared control
  // --------------------------------------------------------------------------
  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        op;
  logic [7:0]        value;
  logic              out_valid;
  logic              out_ready;
  logic              channel;
  logic signed [7:0] sample;
  logic              last;

  sound_scoreboard board;
  int  items_sent;
  int  drains;
  bit  calm;       // no idling on either side while set
  bit  hold_req;   // asks the receiver for one long hold-off
  int  holds_done;

  initial forever #1 clk = ~clk;

  three_voice_sound_generator_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .channel   (channel),
    .sample    (sample),
    .last      (last)
  );

  // --------------------------------------------------------------------------
  // sender tasks: start just after a falling edge, end at the accepting edge
  // --------------------------------------------------------------------------
  task automatic put_item(input op_t kind, input logic [7:0] data);
    @(negedge clk);
    // random idle cycles ahead of the transaction
    while (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= kind;
    value    <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_item(kind, data);
    if (kind != OP_NONE) items_sent++;
  endtask

  // select a register, then write it
  task automatic program_register(input logic [3:0] idx, input logic [7:0] data);
    put_item(OP_FUNC, {BUS_ADDRESS, 6'h00});
    put_item(OP_DATA, {4'h0, idx});
    put_item(OP_FUNC, {BUS_WRITE, 6'h00});
    put_item(OP_DATA, data);
  endtask

  // stop offering and wait until every predicted sample came out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.expected_samples.size() != 0) @(negedge clk);
  endtask

  // register values weighted so the envelope and noise actually move
  function automatic logic [7:0] pick_setting(logic [3:0] idx);
    case (idx)
      REG_ENV_COARSE:
        return ($urandom_range(99) < 85) ? 8'h00 : 8'($urandom);
      REG_ENV_FINE:
        return ($urandom_range(1) == 0) ? 8'($urandom_range(7)) : 8'($urandom);
      REG_TONE_A_COARSE, REG_TONE_B_COARSE, REG_TONE_C_COARSE:
        return ($urandom_range(99) < 70) ? {4'($urandom), 4'h0} : 8'($urandom);
      REG_TONE_A_FINE, REG_TONE_B_FINE, REG_TONE_C_FINE:
        return ($urandom_range(1) == 0) ? 8'($urandom_range(6)) : 8'($urandom);
      REG_NOISE_PERIOD:
        return ($urandom_range(99) < 60) ? 8'($urandom_range(4)) : 8'($urandom);
      default:
        return 8'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // receiver: random stalls, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    out_ready  = 1'b0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long back-pressure: queue fills and the input side must stall
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_req = 1'b0;
        holds_done++;
      end
      out_ready <= calm || ($urandom_range(99) >= 6);
    end
  end

  // output monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_sample(channel, sample, last);
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int         pick;
    int         burst;
    int         next_drain;
    logic [3:0] idx;

    board      = new();
    items_sent = 0;
    drains     = 0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    next_drain = 250;
    rst        = 1'b1;
    in_valid   = 1'b0;
    op         = OP_TICK;
    value      = 8'h00;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: unknown op, writes with the latch inactive or reading
    put_item(OP_NONE, 8'hFF);
    put_item(OP_DATA, 8'h00);
    put_item(OP_FUNC, {BUS_READ, 6'h3F});
    put_item(OP_DATA, 8'hFF);
    // shape write with upper bits set, lands on a repeating triangle
    program_register(REG_ENV_SHAPE, 8'hFE);
    // writes to registers with no storage
    program_register(REG_SPARE_14, 8'hA5);
    program_register(REG_SPARE_15, 8'hFF);
    // all gates on, top mixer bits ignored; zero tone periods toggle every update
    program_register(REG_MIXER, 8'hC0);
    repeat (16) put_item(OP_TICK, 8'hFF);

    // random part
    while (items_sent < RANDOM_ITEMS) begin
      calm = (items_sent >= 450 && items_sent < 700);

      if (holds_done == 0 && !hold_req && items_sent >= 350) begin
        // back-pressure while ticks keep coming
        hold_req = 1'b1;
        repeat (80) put_item(OP_TICK, 8'($urandom));
      end

      if (items_sent >= next_drain) begin
        wait_drained();
        drains++;
        next_drain += 300;
      end

      pick = $urandom_range(99);
      if (pick < 45) begin
        burst = $urandom_range(1, 40);
        repeat (burst) put_item(OP_TICK, 8'($urandom));
      end else if (pick < 80) begin
        idx = 4'($urandom);
        program_register(idx, pick_setting(idx));
      end else if (pick < 90) begin
        // broken or partial bus sequences
        case ($urandom_range(2))
          0: begin
            put_item(OP_FUNC, {BUS_ADDRESS, 6'($urandom)});
            put_item(OP_DATA, 8'($urandom));
          end
          1: begin
            put_item(OP_FUNC, {BUS_WRITE, 6'($urandom)});
            put_item(OP_DATA, 8'($urandom));
          end
          default: begin
            put_item(OP_FUNC, {1'b0, 1'($urandom), 6'($urandom)});
            put_item(OP_DATA, 8'($urandom));
          end
        endcase
      end else begin
        put_item(op_t'($urandom_range(3)), 8'($urandom));
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d input transactions and %0d checked samples", items_sent,
             board.checked);
    $display("with %0d long output hold-offs and %0d full drain pauses", holds_done,
             drains + 1);
    if (board.failures == 0 && board.expected_samples.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
